### sv/mcm_pkg.sv
// Package: shared types and constants for the 4x4 column matrix multiply core.
`default_nettype none
package mcm_pkg;

  localparam int DIM = 4;
  localparam int WORD_W = 32;
  localparam int COL_W = 2;
  localparam int FRAC_BITS_DEFAULT = 16;

  localparam int PROD_W = 2 * WORD_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W = PROD_W + 2;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_MUL  = 1'b1
  } req_type_t;

  typedef logic [DIM-1:0][WORD_W-1:0] quad_t;

  typedef struct packed {
    req_type_t          req_type;
    logic [COL_W-1:0]   column;
    logic signed [31:0] elem0;
    logic signed [31:0] elem1;
    logic signed [31:0] elem2;
    logic signed [31:0] elem3;
  } cmd_word_t;

  typedef struct packed {
    logic [COL_W-1:0]   out_column;
    logic signed [31:0] res0;
    logic signed [31:0] res1;
    logic signed [31:0] res2;
    logic signed [31:0] res3;
    logic               saturated;
  } rsp_word_t;

  typedef struct packed {
    logic en_prod;
    logic en_pair;
    logic en_sum;
  } lane_ctl_t;

endpackage
`default_nettype wire

### sv/mcm_lane.sv
// Row lane: four products, adder tree, shift and saturate for one result row.
`default_nettype none
module mcm_lane #(
  parameter int FRAC_BITS = mcm_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                      clk,
  input  mcm_pkg::lane_ctl_t        ctl,
  input  mcm_pkg::quad_t            coef,
  input  mcm_pkg::quad_t            elem,
  output logic [mcm_pkg::WORD_W-1:0] res,
  output logic                      sat
);
  import mcm_pkg::*;

  logic signed [PROD_W-1:0] prod [DIM];
  logic signed [PAIR_W-1:0] pair_lo;
  logic signed [PAIR_W-1:0] pair_hi;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  shifted;
  logic                     sat_pos;
  logic                     sat_neg;

  always_ff @(posedge clk) begin
    if (ctl.en_prod) begin
      for (int k = 0; k < DIM; k++) begin
        prod[k] <= PROD_W'($signed(coef[k])) * PROD_W'($signed(elem[k]));
      end
    end
    if (ctl.en_pair) begin
      pair_lo <= PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
      pair_hi <= PAIR_W'(prod[2]) + PAIR_W'(prod[3]);
    end
    if (ctl.en_sum) begin
      sum <= SUM_W'(pair_lo) + SUM_W'(pair_hi);
    end
  end

  always_comb begin
    shifted = sum >>> FRAC_BITS;
    sat_pos = !shifted[SUM_W-1] && (|shifted[SUM_W-2:WORD_W-1]);
    sat_neg = shifted[SUM_W-1] && !(&shifted[SUM_W-2:WORD_W-1]);
    sat     = sat_pos || sat_neg;
    if (sat_pos) begin
      res = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (sat_neg) begin
      res = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      res = shifted[WORD_W-1:0];
    end
  end

endmodule
`default_nettype wire

### sv/mcm_merge.sv
// Merge stage: gathers lane rows and flags into the registered response word.
`default_nettype none
module mcm_merge (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sum_valid,
  input  logic [mcm_pkg::COL_W-1:0] sum_column,
  input  mcm_pkg::quad_t           lane_res,
  input  logic [mcm_pkg::DIM-1:0]  lane_sat,
  output logic                     ready,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output mcm_pkg::rsp_word_t       rsp
);
  import mcm_pkg::*;

  logic load;

  assign ready = !rsp_valid || !rsp_stall;
  assign load  = ready && sum_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ready) begin
      rsp_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.out_column <= sum_column;
      rsp.res0       <= $signed(lane_res[0]);
      rsp.res1       <= $signed(lane_res[1]);
      rsp.res2       <= $signed(lane_res[2]);
      rsp.res3       <= $signed(lane_res[3]);
      rsp.saturated  <= |lane_sat;
    end
  end

endmodule
`default_nettype wire

### sv/matrix4_column_multiply_core.sv
// Top level: 4x4 Q16.16 column matrix multiply with four parallel row lanes.
// A multiply word passes the product, pair-sum and sum registers, then the response register,
// before it shows on rsp; a stall downstream can hold it in any of them.
// Throughput: one word per cycle while cmd_stall is low, loads and multiplies alike; loads give no response.
// Load words update the left matrix at the accepting edge, seen by the next word.
// Reset (rst, synchronous) clears the left matrix to zero and empties the pipeline.
`default_nettype none
module matrix4_column_multiply_core #(
  parameter int FRAC_BITS = mcm_pkg::FRAC_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  mcm_pkg::cmd_word_t cmd,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output mcm_pkg::rsp_word_t rsp
);
  import mcm_pkg::*;

  logic [DIM-1:0][DIM-1:0][WORD_W-1:0] left_mat;

  logic             prod_valid, pair_valid, sum_valid;
  logic [COL_W-1:0] prod_column, pair_column, sum_column;
  logic             prod_ready, pair_ready, sum_ready, merge_ready;
  logic             accept, mul_accept, load_accept;
  lane_ctl_t        ctl;
  quad_t            elem;
  quad_t            lane_res;
  logic [DIM-1:0]   lane_sat;

  assign sum_ready  = !sum_valid || merge_ready;
  assign pair_ready = !pair_valid || sum_ready;
  assign prod_ready = !prod_valid || pair_ready;
  assign cmd_stall  = !prod_ready;

  assign accept      = cmd_valid && prod_ready;
  assign mul_accept  = accept && (cmd.req_type == REQ_MUL);
  assign load_accept = accept && (cmd.req_type == REQ_LOAD);

  assign ctl.en_prod = mul_accept;
  assign ctl.en_pair = pair_ready && prod_valid;
  assign ctl.en_sum  = sum_ready && pair_valid;

  assign elem = {cmd.elem3, cmd.elem2, cmd.elem1, cmd.elem0};

  always_ff @(posedge clk) begin
    if (rst) begin
      left_mat <= '0;
    end else if (load_accept) begin
      left_mat[cmd.column] <= elem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      pair_valid <= 1'b0;
      sum_valid  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid <= mul_accept;
      end
      if (pair_ready) begin
        pair_valid <= prod_valid;
      end
      if (sum_ready) begin
        sum_valid <= pair_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_prod) begin
      prod_column <= cmd.column;
    end
    if (ctl.en_pair) begin
      pair_column <= prod_column;
    end
    if (ctl.en_sum) begin
      sum_column <= pair_column;
    end
  end

  for (genvar r = 0; r < DIM; r++) begin : g_lane
    quad_t coef;

    for (genvar k = 0; k < DIM; k++) begin : g_coef
      assign coef[k] = left_mat[k][r];
    end

    mcm_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk (clk),
      .ctl (ctl),
      .coef(coef),
      .elem(elem),
      .res (lane_res[r]),
      .sat (lane_sat[r])
    );
  end

  mcm_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (sum_valid),
    .sum_column(sum_column),
    .lane_res  (lane_res),
    .lane_sat  (lane_sat),
    .ready     (merge_ready),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

### dv/tb_matrix4_column_multiply_core.sv
// Testbench: random and directed column words against a Q16.16 4x4 column product predictor.
`timescale 1ns / 100ps
module tb_matrix4_column_multiply_core;
  import mcm_pkg::*;

  localparam int FRAC = FRAC_BITS_DEFAULT;
  localparam int HOLD_CYCLES = 200;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  cmd_word_t cmd = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_word_t rsp;

  cmd_word_t   cmd_pending_q [$];
  rsp_word_t   product_expect_q [$];
  logic [31:0] left_cols [DIM*DIM];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_armed = 1'b0;
  logic        hold_done;
  int unsigned hold_left;
  int unsigned err_count = 0;

  matrix4_column_multiply_core #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic rsp_word_t column_product(cmd_word_t c);
    rsp_word_t          r;
    logic signed [31:0] vin [DIM];
    logic signed [31:0] rows [DIM];
    logic signed [63:0] p;
    logic signed [65:0] acc;
    r = '0;
    vin[0] = c.elem0;
    vin[1] = c.elem1;
    vin[2] = c.elem2;
    vin[3] = c.elem3;
    for (int i = 0; i < DIM; i++) begin
      acc = '0;
      for (int k = 0; k < DIM; k++) begin
        p = $signed(left_cols[k*DIM+i]) * vin[k];
        acc = acc + p;
      end
      acc = acc >>> FRAC;
      if (acc[65:31] != {35{acc[65]}}) begin
        r.saturated = 1'b1;
        rows[i] = acc[65] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else begin
        rows[i] = acc[31:0];
      end
    end
    r.out_column = c.column;
    r.res0 = rows[0];
    r.res1 = rows[1];
    r.res2 = rows[2];
    r.res3 = rows[3];
    return r;
  endfunction

  task automatic apply_word(cmd_word_t c);
    if (c.req_type == REQ_LOAD) begin
      left_cols[c.column*DIM+0] = c.elem0;
      left_cols[c.column*DIM+1] = c.elem1;
      left_cols[c.column*DIM+2] = c.elem2;
      left_cols[c.column*DIM+3] = c.elem3;
    end else begin
      product_expect_q.push_back(column_product(c));
    end
  endtask

  task automatic flag_mismatch(input string what);
    err_count++;
    if (err_count <= 50) $display("%0t ERROR: %s", $time, what);
  endtask

  task automatic push_word(req_type_t t, logic [1:0] col, logic [31:0] e0, logic [31:0] e1,
                           logic [31:0] e2, logic [31:0] e3);
    cmd_word_t c;
    c.req_type = t;
    c.column = col;
    c.elem0 = e0;
    c.elem1 = e1;
    c.elem2 = e2;
    c.elem3 = e3;
    cmd_pending_q.push_back(c);
  endtask

  function automatic logic [31:0] rand_elem();
    logic [31:0] b;
    b = $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3: return {{12{b[19]}}, b[19:0]};
      4, 5:       return b;
      6:          return 32'h7FFFFFFF;
      7:          return 32'h80000000;
      8:          return 32'h00000000;
      default:    return b[0] ? 32'hFFFFFFFF : 32'h00000001;
    endcase
  endfunction

  task automatic add_random(int unsigned n);
    for (int i = 0; i < n; i++) begin
      push_word(($urandom_range(99) < 35) ? REQ_LOAD : REQ_MUL, 2'($urandom_range(3)),
                rand_elem(), rand_elem(), rand_elem(), rand_elem());
    end
  endtask

  task automatic add_directed();
    // never loaded: left matrix still zero
    push_word(REQ_MUL, 2'd0, 32'h00010000, 32'hFFFF0000, 32'h7FFFFFFF, 32'h80000000);
    // identity, then a multiply right behind the last load
    push_word(REQ_LOAD, 2'd0, 32'h00010000, 32'h0, 32'h0, 32'h0);
    push_word(REQ_LOAD, 2'd1, 32'h0, 32'h00010000, 32'h0, 32'h0);
    push_word(REQ_LOAD, 2'd2, 32'h0, 32'h0, 32'h00010000, 32'h0);
    push_word(REQ_LOAD, 2'd3, 32'h0, 32'h0, 32'h0, 32'h00010000);
    push_word(REQ_MUL, 2'd1, 32'h12345678, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
    // full-scale left matrix: saturate both ways, widest sums
    push_word(REQ_LOAD, 2'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000);
    push_word(REQ_LOAD, 2'd1, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
    push_word(REQ_LOAD, 2'd2, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000);
    push_word(REQ_LOAD, 2'd3, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
    push_word(REQ_MUL, 2'd3, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    push_word(REQ_MUL, 2'd2, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    push_word(REQ_MUL, 2'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    // truncation toward minus infinity on tiny products
    push_word(REQ_LOAD, 2'd0, 32'h00000001, 32'hFFFFFFFF, 32'h00008000, 32'hFFFF8000);
    push_word(REQ_LOAD, 2'd1, 32'h0, 32'h0, 32'h0, 32'h0);
    push_word(REQ_LOAD, 2'd2, 32'h0, 32'h0, 32'h0, 32'h0);
    push_word(REQ_LOAD, 2'd3, 32'h0, 32'h0, 32'h0, 32'h0);
    push_word(REQ_MUL, 2'd2, 32'h00000001, 32'h0, 32'h0, 32'h0);
    push_word(REQ_MUL, 2'd3, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h0);
    push_word(REQ_MUL, 2'd1, 32'h00018000, 32'h0, 32'h0, 32'h0);
  endtask

  task automatic wait_drained();
    while (cmd_pending_q.size() != 0 || cmd_valid || product_expect_q.size() != 0)
      @(posedge clk);
  endtask

  // driver: a word is accepted when valid and not stalled
  always @(posedge clk) begin : drive_p
    cmd_word_t nxt;
    logic      nxt_valid;
    if (rst) begin
      cmd_valid <= 1'b0;
      cmd <= '0;
      foreach (left_cols[i]) left_cols[i] = '0;
    end else begin
      if (cmd_valid && !cmd_stall) apply_word(cmd);
      if (!cmd_valid || !cmd_stall) begin
        nxt = cmd;
        nxt_valid = 1'b0;
        if (cmd_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = cmd_pending_q.pop_front();
          nxt_valid = 1'b1;
        end
        cmd_valid <= nxt_valid;
        cmd <= nxt;
      end
    end
  end

  // receiver stall, with one long hold-off when armed
  always @(posedge clk) begin : stall_p
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= (hold_left != 1);
    end else if (hold_armed && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : watch_p
    rsp_word_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (product_expect_q.size() == 0) begin
        flag_mismatch($sformatf("response word with none pending: %h", rsp));
      end else begin
        want = product_expect_q.pop_front();
        if (rsp.out_column !== want.out_column)
          flag_mismatch($sformatf("out_column %0d, want %0d", rsp.out_column, want.out_column));
        if (rsp.res0 !== want.res0)
          flag_mismatch($sformatf("res0 %h, want %h", rsp.res0, want.res0));
        if (rsp.res1 !== want.res1)
          flag_mismatch($sformatf("res1 %h, want %h", rsp.res1, want.res1));
        if (rsp.res2 !== want.res2)
          flag_mismatch($sformatf("res2 %h, want %h", rsp.res2, want.res2));
        if (rsp.res3 !== want.res3)
          flag_mismatch($sformatf("res3 %h, want %h", rsp.res3, want.res3));
        if (rsp.saturated !== want.saturated)
          flag_mismatch($sformatf("saturated %b, want %b", rsp.saturated, want.saturated));
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct <= 31;
    recv_idle_pct <= 72;
    add_directed();
    add_random(310);
    wait_drained();
    send_idle_pct <= 72;
    recv_idle_pct <= 31;
    add_random(310);
    wait_drained();
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    hold_armed <= 1'b1;
    add_random(310);
    wait_drained();
    repeat (20) @(posedge clk);
    if (err_count == 0 && product_expect_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout, %0d words still expected", product_expect_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
